// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms used by the top RTL file of the evaluator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ETV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition leads to another at the next edge.
`define ETV_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/etv_pkg.sv =====
// ----------------------------------------------------------------------------
// etv_pkg
// Types, codes and preset curves of the eased transition value evaluator.
// ----------------------------------------------------------------------------
package etv_pkg;

    localparam int BISECT_STEPS_DEF = 12;
    localparam int Q_DEPTH          = 4;

    localparam int IN_DATA_W  = 216;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    localparam logic [2:0] KIND_LINEAR      = 3'd0;
    localparam logic [2:0] KIND_EASE        = 3'd1;
    localparam logic [2:0] KIND_EASE_IN     = 3'd2;
    localparam logic [2:0] KIND_EASE_OUT    = 3'd3;
    localparam logic [2:0] KIND_EASE_IN_OUT = 3'd4;
    localparam logic [2:0] KIND_BEZIER      = 3'd5;
    localparam logic [2:0] KIND_STEPS       = 3'd6;

    localparam logic [1:0] STEP_END      = 2'd0;
    localparam logic [1:0] STEP_END_HOLD = 2'd1;
    localparam logic [1:0] STEP_NONE     = 2'd2;
    localparam logic [1:0] STEP_BOTH     = 2'd3;

    localparam logic signed [31:0] VAL_MAX = 32'sd8388607;
    localparam logic signed [31:0] VAL_MIN = -32'sd8388608;

    typedef enum logic [1:0] {
        PH_DELAY  = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [9:0]          progress;
        logic signed [23:0]  sv;
        logic signed [23:0]  tv;
        logic [2:0]          kind;
        logic [16:0]         x1;
        logic signed [18:0]  y1;
        logic [16:0]         x2;
        logic signed [18:0]  y2;
        logic [9:0]          steps;
        logic [1:0]          mode;
    } t_job;

    typedef struct packed {
        logic signed [19:0] x1;
        logic signed [19:0] y1;
        logic signed [19:0] x2;
        logic signed [19:0] y2;
    } t_curve;

    typedef struct packed {
        t_phase              phase;
        logic [9:0]          progress;
        logic signed [23:0]  sv;
        logic signed [23:0]  tv;
        t_curve              curve;
        logic                use_bez;
        logic [10:0]         pre;
    } t_bjob;

    typedef struct packed {
        logic [32:0] lo;
        logic [32:0] hi;
        t_bjob       job;
    } t_bis;

    function automatic t_curve preset_curve(input logic [2:0] kind);
        t_curve c;
        case (kind)
            KIND_EASE:        c = '{20'sd16384, 20'sd6554, 20'sd16384, 20'sd65536};
            KIND_EASE_IN:     c = '{20'sd27525, 20'sd0, 20'sd65536, 20'sd65536};
            KIND_EASE_OUT:    c = '{20'sd0, 20'sd0, 20'sd38011, 20'sd65536};
            KIND_EASE_IN_OUT: c = '{20'sd27525, 20'sd0, 20'sd38011, 20'sd65536};
            default:          c = '{20'sd0, 20'sd0, 20'sd0, 20'sd0};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/etv_div.sv =====
// ----------------------------------------------------------------------------
// etv_div
// Pipelined restoring divider, one quotient bit per stage, side data carried.
// ----------------------------------------------------------------------------
module etv_div #(
    parameter int NW = 29,
    parameter int DW = 19,
    parameter int QW = 10,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);
    localparam int LW = NW + QW;

    logic [NW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quot [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_v;

    for (genvar g = 0; g < QW; g++) begin : g_st
        logic [NW-1:0] rem_in;
        logic [QW-1:0] quot_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_in;
        logic          v_in;
        logic [LW-1:0] shd;
        logic [LW-1:0] rem_ext;
        logic          ge;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quot;

        if (g == 0) begin : g_first
            assign rem_in  = i_num;
            assign quot_in = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign quot_in = r_quot[g-1];
            assign den_in  = r_den[g-1];
            assign side_in = r_side[g-1];
            assign v_in    = r_v[g-1];
        end

        assign shd     = LW'(den_in) << (QW - 1 - g);
        assign rem_ext = {{QW{1'b0}}, rem_in};
        assign ge      = rem_ext >= shd;

        always_comb begin
            n_rem  = ge ? NW'(rem_ext - shd) : rem_in;
            n_quot = ge ? (quot_in | (QW'(1) << (QW - 1 - g))) : quot_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_quot[g] <= n_quot;
                r_den[g]  <= den_in;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== rtl/etv_bez.sv =====
// ----------------------------------------------------------------------------
// etv_bez
// Five-stage evaluation of one cubic bezier coordinate, Q.32 parameter in.
// ----------------------------------------------------------------------------
module etv_bez #(
    parameter int SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [31:0]        i_u,
    input  logic signed [19:0] i_p1,
    input  logic signed [19:0] i_p2,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic signed [39:0] o_val,
    output logic [SW-1:0]      o_side
);
    logic [4:0]          r_v;
    logic [SW-1:0]       r_side [5];
    logic signed [19:0]  r_p1 [3];
    logic signed [19:0]  r_p2 [3];

    logic [31:0] r1_u, r1_om;
    logic [31:0] r2_u, r2_om, r2_u2, r2_om2;
    logic [31:0] r3_u3, r3_wa, r3_wb;
    logic [31:0] r4_u3;
    logic signed [52:0] r4_pa, r4_pb;
    logic signed [39:0] r5_val;

    logic [63:0] w_om_sq, w_u_sq, w_u3, w_wa, w_wb;
    logic signed [52:0] w_pa, w_pb, w_ta, w_tb;
    logic signed [39:0] w_sum;

    assign w_om_sq = {32'b0, r1_om} * {32'b0, r1_om};
    assign w_u_sq  = {32'b0, r1_u} * {32'b0, r1_u};
    assign w_u3    = {32'b0, r2_u2} * {32'b0, r2_u};
    assign w_wa    = {32'b0, r2_om2} * {32'b0, r2_u};
    assign w_wb    = {32'b0, r2_om} * {32'b0, r2_u2};
    assign w_pa    = $signed({1'b0, r3_wa}) * r_p1[2];
    assign w_pb    = $signed({1'b0, r3_wb}) * r_p2[2];

    // Divide by 2^16 towards zero.
    assign w_ta  = (r4_pa + (r4_pa[52] ? 53'sd65535 : 53'sd0)) >>> 16;
    assign w_tb  = (r4_pb + (r4_pb[52] ? 53'sd65535 : 53'sd0)) >>> 16;
    assign w_sum = 40'sd3 * 40'(w_ta) + 40'sd3 * 40'(w_tb) + $signed({8'b0, r4_u3});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < 5; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_p1[0] <= i_p1;
            r_p2[0] <= i_p2;
            for (int i = 1; i < 3; i++) begin
                r_p1[i] <= r_p1[i-1];
                r_p2[i] <= r_p2[i-1];
            end
            r1_u   <= i_u;
            r1_om  <= 32'(33'h1_0000_0000 - {1'b0, i_u});
            r2_u   <= r1_u;
            r2_om  <= r1_om;
            r2_u2  <= w_u_sq[63:32];
            r2_om2 <= w_om_sq[63:32];
            r3_u3  <= w_u3[63:32];
            r3_wa  <= w_wa[63:32];
            r3_wb  <= w_wb[63:32];
            r4_u3  <= r3_u3;
            r4_pa  <= w_pa;
            r4_pb  <= w_pb;
            r5_val <= w_sum;
        end
    end

    assign o_valid = r_v[4];
    assign o_val   = r5_val;
    assign o_side  = r_side[4];

endmodule

// ===== rtl/etv_front.sv =====
// ----------------------------------------------------------------------------
// etv_front
// Accept items, convert times to ticks, classify the phase, divide progress.
// ----------------------------------------------------------------------------
module etv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_elapsed,
    input  logic signed [23:0]  i_delay,
    input  logic [22:0]         i_duration,
    input  etv_pkg::t_job       i_job,
    input  logic                i_full,
    output logic                o_valid,
    output etv_pkg::t_job       o_job
);
    logic en;

    logic               r0_v, r1_v, r2_v;
    logic [31:0]        r0_elapsed, r1_elapsed;
    logic signed [23:0] r0_delay;
    logic [22:0]        r0_dur;
    etv_pkg::t_job      r0_job, r1_job, r2_job;
    logic [18:0]        r1_dt;
    logic               r1_zero;
    logic [19:0]        r1_dmag;
    logic               r1_dneg;
    logic [28:0]        r2_num;
    logic [18:0]        r2_den;

    logic [23:0]        w_dabs;
    logic [15:0]        w_dfrac, w_ufrac;
    logic [18:0]        w_dur_ticks;
    logic [19:0]        w_dly_ticks;
    logic signed [33:0] w_dly, w_eff;
    etv_pkg::t_job      n_job;
    logic [28:0]        n_num;

    logic [$bits(etv_pkg::t_job)-1:0] w_dside;
    logic [9:0]                       w_quot;
    etv_pkg::t_job                    w_djob;

    // Hold the whole front when its result cannot enter the queue.
    assign en      = !o_valid || !i_full;
    assign o_ready = en;

    // Seconds in Q.10 to 60 Hz ticks, rounded.
    assign w_dabs      = r0_delay[23] ? 24'(-r0_delay) : 24'(r0_delay);
    assign w_ufrac     = {6'b0, r0_dur[9:0]} * 16'd60 + 16'd512;
    assign w_dfrac     = {6'b0, w_dabs[9:0]} * 16'd60 + 16'd512;
    assign w_dur_ticks = {6'b0, r0_dur[22:10]} * 19'd60 + {13'b0, w_ufrac[15:10]};
    assign w_dly_ticks = {6'b0, w_dabs[23:10]} * 20'd60 + {14'b0, w_dfrac[15:10]};

    assign w_dly = r1_dneg ? -$signed({14'b0, r1_dmag}) : $signed({14'b0, r1_dmag});
    assign w_eff = $signed({2'b00, r1_elapsed}) - w_dly;

    always_comb begin
        n_job = r1_job;
        n_num = '0;
        if (r1_zero) begin
            n_job.phase = etv_pkg::PH_DONE;
        end else if (w_eff < 0) begin
            n_job.phase = etv_pkg::PH_DELAY;
        end else if (w_eff >= $signed({15'b0, r1_dt})) begin
            n_job.phase = etv_pkg::PH_DONE;
        end else begin
            n_job.phase = etv_pkg::PH_ACTIVE;
            n_num       = {w_eff[18:0], 10'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_elapsed <= i_elapsed;
            r0_delay   <= i_delay;
            r0_dur     <= i_duration;
            r0_job     <= i_job;
            r1_elapsed <= r0_elapsed;
            r1_job     <= r0_job;
            r1_zero    <= r0_dur == '0;
            r1_dt      <= (r0_dur != '0 && w_dur_ticks == '0) ? 19'd1 : w_dur_ticks;
            r1_dmag    <= w_dly_ticks;
            r1_dneg    <= r0_delay[23];
            r2_job     <= n_job;
            r2_num     <= n_num;
            r2_den     <= r1_dt;
        end
    end

    etv_div #(
        .NW(29),
        .DW(19),
        .QW(10),
        .SW($bits(etv_pkg::t_job))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  (r2_job),
        .o_valid (o_valid),
        .o_quot  (w_quot),
        .o_side  (w_dside)
    );

    always_comb begin
        w_djob          = etv_pkg::t_job'(w_dside);
        w_djob.progress = w_quot;
        o_job           = w_djob;
    end

endmodule

// ===== rtl/etv_back.sv =====
// ----------------------------------------------------------------------------
// etv_back
// Easing (steps divider, bisection bezier solve) and saturating interpolation.
// ----------------------------------------------------------------------------
module etv_back #(
    parameter int BISECT_STEPS = etv_pkg::BISECT_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  etv_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_value,
    output logic [1:0]         o_phase
);
    localparam int DSW = $bits(etv_pkg::t_bjob) + 1;

    logic en;

    logic               r0_v, r1_v;
    etv_pkg::t_job      r0_job;
    logic [19:0]        r0_sprod;
    logic [19:0]        r1_num;
    logic [10:0]        r1_den;
    etv_pkg::t_bjob     r1_job;
    logic               r1_use_div;

    logic [9:0]         w_s;
    etv_pkg::t_bjob     n_job;
    logic [9:0]         n_n;
    logic [10:0]        n_d;
    logic               n_use_div;

    logic               d_v;
    logic [9:0]         d_quot;
    logic [DSW-1:0]     d_side;

    etv_pkg::t_bis      w_bis [BISECT_STEPS+1];
    logic [BISECT_STEPS:0] w_v;

    logic               y_v;
    logic signed [39:0] y_val;
    logic [$bits(etv_pkg::t_bjob)-1:0] y_side;
    etv_pkg::t_bjob     y_job;
    logic [31:0]        y_mid;
    logic signed [39:0] w_yr;
    logic [13:0]        n_eased;

    logic               r_y_v, r_i1_v, r_i2_v, r_ov;
    logic [13:0]        r_y_eased;
    etv_pkg::t_bjob     r_y_job, r_i1_job, r_i2_job;
    logic signed [39:0] r_i1_prod;
    logic signed [31:0] r_i2_sum;
    logic signed [24:0] w_diff;
    logic signed [39:0] w_q;
    logic signed [23:0] n_value;
    logic signed [23:0] r_value;
    logic [1:0]         r_phase;

    // Advance every stage whenever the output register is free or drains.
    assign en    = !r_ov || i_ready;
    assign o_pop = en && i_valid;

    always_comb begin
        w_s             = r0_sprod[19:10];
        n_job.phase     = r0_job.phase;
        n_job.progress  = r0_job.progress;
        n_job.sv        = r0_job.sv;
        n_job.tv        = r0_job.tv;
        n_job.pre       = {1'b0, r0_job.progress};
        n_job.use_bez   = (r0_job.kind inside {[etv_pkg::KIND_EASE:etv_pkg::KIND_BEZIER]})
                          && r0_job.progress != '0;
        if (r0_job.kind == etv_pkg::KIND_BEZIER) begin
            n_job.curve = '{$signed({3'b0, r0_job.x1}), 20'(r0_job.y1),
                            $signed({3'b0, r0_job.x2}), 20'(r0_job.y2)};
        end else begin
            n_job.curve = etv_pkg::preset_curve(r0_job.kind);
        end
        n_n       = w_s;
        n_d       = {1'b0, r0_job.steps};
        n_use_div = 1'b0;
        if (r0_job.kind == etv_pkg::KIND_STEPS && r0_job.steps != '0) begin
            n_use_div = 1'b1;
            case (r0_job.mode)
                etv_pkg::STEP_NONE: begin
                    if (w_s == '0) begin
                        n_use_div = 1'b0;
                        n_job.pre = '0;
                    end else begin
                        n_n = w_s - 10'd1;
                        n_d = {1'b0, r0_job.steps} - 11'd1;
                    end
                end
                etv_pkg::STEP_BOTH: begin
                    n_n = w_s + 10'd1;
                    n_d = {1'b0, r0_job.steps} + 11'd1;
                end
                default: begin
                    n_n = w_s;
                    n_d = {1'b0, r0_job.steps};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_job     <= i_job;
            r0_sprod   <= {10'b0, i_job.progress} * {10'b0, i_job.steps};
            r1_job     <= n_job;
            r1_num     <= {n_n, 10'b0};
            r1_den     <= n_d;
            r1_use_div <= n_use_div;
        end
    end

    etv_div #(
        .NW(20),
        .DW(11),
        .QW(10),
        .SW(DSW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_num   (r1_num),
        .i_den   (r1_den),
        .i_side  ({r1_use_div, r1_job}),
        .o_valid (d_v),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    always_comb begin
        w_bis[0].lo  = '0;
        w_bis[0].hi  = 33'h1_0000_0000;
        w_bis[0].job = etv_pkg::t_bjob'(d_side[DSW-2:0]);
        if (d_side[DSW-1]) begin
            w_bis[0].job.pre = {1'b0, d_quot};
        end
    end
    assign w_v[0] = d_v;

    // Bisection on x: each step is one bezier evaluation and one compare stage.
    for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_bis
        logic               e_v;
        logic signed [39:0] e_val;
        logic [$bits(etv_pkg::t_bis)-1:0] e_raw;
        etv_pkg::t_bis      e_side;
        logic [31:0]        mid_in, mid_out;
        logic               lt;
        etv_pkg::t_bis      n_bis;
        etv_pkg::t_bis      r_bis;
        logic               r_v;

        assign mid_in = 32'((w_bis[k].lo + w_bis[k].hi) >> 1);

        etv_bez #(
            .SW($bits(etv_pkg::t_bis))
        ) u_eval (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_v[k]),
            .i_u     (mid_in),
            .i_p1    (w_bis[k].job.curve.x1),
            .i_p2    (w_bis[k].job.curve.x2),
            .i_side  (w_bis[k]),
            .o_valid (e_v),
            .o_val   (e_val),
            .o_side  (e_raw)
        );

        assign e_side  = etv_pkg::t_bis'(e_raw);
        assign mid_out = 32'((e_side.lo + e_side.hi) >> 1);
        assign lt      = e_val < $signed({8'b0, e_side.job.progress, 22'b0});

        always_comb begin
            n_bis = e_side;
            if (lt) begin
                n_bis.lo = {1'b0, mid_out};
            end else begin
                n_bis.hi = {1'b0, mid_out};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (en) begin
                r_v <= e_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_bis <= n_bis;
            end
        end

        assign w_bis[k+1] = r_bis;
        assign w_v[k+1]   = r_v;
    end

    assign y_mid = 32'((w_bis[BISECT_STEPS].lo + w_bis[BISECT_STEPS].hi) >> 1);

    etv_bez #(
        .SW($bits(etv_pkg::t_bjob))
    ) u_yeval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_v[BISECT_STEPS]),
        .i_u     (y_mid),
        .i_p1    (w_bis[BISECT_STEPS].job.curve.y1),
        .i_p2    (w_bis[BISECT_STEPS].job.curve.y2),
        .i_side  (w_bis[BISECT_STEPS].job),
        .o_valid (y_v),
        .o_val   (y_val),
        .o_side  (y_side)
    );

    assign y_job = etv_pkg::t_bjob'(y_side);
    assign w_yr  = (y_val + 40'sd2097152) >>> 22;

    always_comb begin
        if (!y_job.use_bez) begin
            n_eased = {3'b0, y_job.pre};
        end else if (y_val < 0) begin
            n_eased = '0;
        end else begin
            n_eased = 14'(w_yr);
        end
    end

    // Interpolate, dividing by 1024 towards zero, then saturate.
    assign w_diff = 25'(r_y_job.tv) - 25'(r_y_job.sv);
    assign w_q    = (r_i1_prod + (r_i1_prod[39] ? 40'sd1023 : 40'sd0)) >>> 10;

    always_comb begin
        case (r_i2_job.phase)
            etv_pkg::PH_DELAY: n_value = r_i2_job.sv;
            etv_pkg::PH_ACTIVE: begin
                if (r_i2_sum > etv_pkg::VAL_MAX) begin
                    n_value = 24'(etv_pkg::VAL_MAX);
                end else if (r_i2_sum < etv_pkg::VAL_MIN) begin
                    n_value = 24'(etv_pkg::VAL_MIN);
                end else begin
                    n_value = 24'(r_i2_sum);
                end
            end
            default: n_value = r_i2_job.tv;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v  <= 1'b0;
            r_i1_v <= 1'b0;
            r_i2_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_y_v  <= y_v;
            r_i1_v <= r_y_v;
            r_i2_v <= r_i1_v;
            r_ov   <= r_i2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y_eased <= n_eased;
            r_y_job   <= y_job;
            r_i1_prod <= w_diff * $signed({1'b0, r_y_eased});
            r_i1_job  <= r_y_job;
            r_i2_sum  <= 32'(r_i1_job.sv) + 32'(w_q);
            r_i2_job  <= r_i1_job;
            r_value   <= n_value;
            r_phase   <= r_i2_job.phase;
        end
    end

    assign o_valid = r_ov;
    assign o_value = r_value;
    assign o_phase = r_phase;

endmodule

// ===== rtl/eased_transition_value_evaluator.sv =====
// ----------------------------------------------------------------------------
// eased_transition_value_evaluator
// Evaluate the presented value of a timed, eased transition for one item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one transfer per item carrying elapsed ticks, delay and
//   duration (Q.10 seconds), start and target values, bezier controls and
//   steps settings in tdata, and the timing kind in tuser.
//   Master channel: one transfer per item, presented value in tdata and the
//   phase (delay, active, complete) in tuser, in input order.
//   Throughput: one item per cycle, sustained while the receiver keeps up.
//   The path from input to result runs through the twelve bisection
//   steps of the default, each a five-stage bezier evaluation plus a
//   compare stage, and through the two ten-stage restoring dividers
//   (progress, steps).
//   A four-entry queue parts the front (tick conversion, phase, progress)
//   from the back (easing, interpolation). When the receiver stalls the back
//   holds in place; the front runs on until the queue fills, then drops
//   tready.
//   Reset (synchronous, active low) empties the queue and clears all valid
//   bits; the block has no other state and no configuration.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eased_transition_value_evaluator #(
    parameter int BISECT_STEPS = etv_pkg::BISECT_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // elapsed ticks, delay, duration, start, target,
    // curve_x1, curve_y1, curve_x2, curve_y2, steps, step_position, pad
    input  logic [etv_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic [etv_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // presented_value
    output logic [etv_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // phase
    output logic [etv_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    localparam int QAW = $clog2(etv_pkg::Q_DEPTH);
    localparam int QCW = $clog2(etv_pkg::Q_DEPTH + 1);

    etv_pkg::t_job in_job;
    etv_pkg::t_job f_job;
    logic          f_valid;
    logic          push, pop, full;

    etv_pkg::t_job    r_q_mem [etv_pkg::Q_DEPTH];
    logic [QAW-1:0]   r_q_wp, r_q_rp;
    logic [QCW-1:0]   r_q_cnt;
    logic [QAW-1:0]   n_q_wp, n_q_rp;
    logic [QCW-1:0]   n_q_cnt;

    logic signed [23:0] b_value;

    // Unpack the input transfer; phase and progress are filled in by the front.
    always_comb begin
        in_job.phase    = etv_pkg::PH_DELAY;
        in_job.progress = '0;
        in_job.sv       = s_axis_tdata[102:79];
        in_job.tv       = s_axis_tdata[126:103];
        in_job.kind     = s_axis_tuser[2:0];
        in_job.x1       = s_axis_tdata[143:127];
        in_job.y1       = s_axis_tdata[162:144];
        in_job.x2       = s_axis_tdata[179:163];
        in_job.y2       = s_axis_tdata[198:180];
        in_job.steps    = s_axis_tdata[208:199];
        in_job.mode     = s_axis_tdata[210:209];
    end

    etv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_elapsed  (s_axis_tdata[31:0]),
        .i_delay    (s_axis_tdata[55:32]),
        .i_duration (s_axis_tdata[78:56]),
        .i_job      (in_job),
        .i_full     (full),
        .o_valid    (f_valid),
        .o_job      (f_job)
    );

    // Queue between front and back; the front stalls only on a full queue.
    assign full = r_q_cnt == QCW'(etv_pkg::Q_DEPTH);
    assign push = f_valid && !full;

    always_comb begin
        n_q_wp  = push ? QAW'(r_q_wp + 1'b1) : r_q_wp;
        n_q_rp  = pop ? QAW'(r_q_rp + 1'b1) : r_q_rp;
        n_q_cnt = r_q_cnt + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= '0;
            r_q_rp  <= '0;
            r_q_cnt <= '0;
        end else begin
            r_q_wp  <= n_q_wp;
            r_q_rp  <= n_q_rp;
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mem[r_q_wp] <= f_job;
        end
    end

    etv_back #(
        .BISECT_STEPS(BISECT_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_q_cnt != '0),
        .i_job   (r_q_mem[r_q_rp]),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (b_value),
        .o_phase (m_axis_tuser)
    );

    assign m_axis_tdata = b_value;

    `ETV_ASSERT(a_q_bound, r_q_cnt <= QCW'(etv_pkg::Q_DEPTH), "queue count beyond depth")
    `ETV_ASSERT(a_q_no_ovf, !push || r_q_cnt != QCW'(etv_pkg::Q_DEPTH), "write to full queue")
    `ETV_ASSERT(a_q_no_udf, !pop || r_q_cnt != '0, "read from empty queue")
    `ETV_ASSERT_NEXT(a_q_stays_empty, r_q_cnt == '0 && !push, r_q_cnt == '0, "empty queue filled")

endmodule
